### design/twims_pkg.sv
// Shared codes and types for the TWI master transaction sequencer.
`default_nettype none
package twims_pkg;

  // request actions
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_EVENT = 2'd2;

  // data kinds on the result
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TX   = 2'd1;
  localparam logic [1:0] KIND_RX   = 2'd2;

  // reply status codes
  localparam logic [1:0] RPL_OK        = 2'd0;
  localparam logic [1:0] RPL_ADDR_NACK = 2'd1;
  localparam logic [1:0] RPL_DATA_NACK = 2'd2;
  localparam logic [1:0] RPL_BAD_STAT  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_FIRST_ADDR  = 3'd0;
  localparam logic [2:0] CFG_FIRST_CNT   = 3'd1;
  localparam logic [2:0] CFG_SECOND_EN   = 3'd2;
  localparam logic [2:0] CFG_SECOND_ADDR = 3'd3;
  localparam logic [2:0] CFG_SECOND_CNT  = 3'd4;

  // bus engine status codes, after masking
  localparam logic [7:0] ST_MASK         = 8'hf8;
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_RESTART      = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
  localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
  localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
  localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
  localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

  // write port of the byte buffer
  typedef struct packed {
    logic       en;
    logic       req;
    logic [3:0] idx;
    logic [7:0] data;
  } wbuf_wr_t;

endpackage
`default_nettype wire

### design/twi_master_transaction_sequencer.sv
// Top level of the TWI master transaction sequencer.
//
//  port group | direction | handshake             | carries
//  in_*       | input     | in_valid / in_ready   | action, write byte, bus status, rx byte
//  out_*      | output    | out_valid / out_ready | bus command, data byte, reply
//  cfg_*      | input     | cfg_we                | request addresses and byte counts
//
// Every accepted request yields exactly one result, registered in the cycle after it is taken.
// A new request is taken every cycle while the result register is empty or drained.
// The buffer byte for the current position is prefetched into a register, so the
// whole step is one pass from the request ports to the result register.
// Synchronous reset puts the sequencer idle; buffer contents are undefined.
// A stalled result holds in_ready low until out_ready takes it.
`default_nettype none
module twi_master_transaction_sequencer #(
  parameter int MAX_BYTES = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [1:0]  in_action,
  input  wire        in_load_request,
  input  wire [3:0]  in_load_index,
  input  wire [7:0]  in_load_byte,
  input  wire [7:0]  in_bus_status,
  input  wire [7:0]  in_rx_byte,
  output logic       out_valid,
  input  wire        out_ready,
  output logic       out_ctrl_valid,
  output logic       out_start_cmd,
  output logic       out_send_stop,
  output logic       out_ack_next,
  output logic       out_bus_enable,
  output logic [1:0] out_data_kind,
  output logic [7:0] out_data_value,
  output logic [3:0] out_data_index,
  output logic       out_reply_valid,
  output logic       out_reply_request,
  output logic [1:0] out_reply_status,
  output logic       out_finished,
  input  wire        cfg_we,
  input  wire [2:0]  cfg_index,
  input  wire [7:0]  cfg_data
);
  import twims_pkg::*;

  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_START   = 3'd1;
  localparam logic [2:0] PH_MT_ADDR = 3'd2;
  localparam logic [2:0] PH_MT_DATA = 3'd3;
  localparam logic [2:0] PH_MR_ADDR = 3'd4;
  localparam logic [2:0] PH_MR_DATA = 3'd5;

  typedef struct packed {
    logic       ctrl_valid;
    logic       start_cmd;
    logic       send_stop;
    logic       ack_next;
    logic       bus_enable;
    logic [1:0] data_kind;
    logic [7:0] data_value;
    logic [3:0] data_index;
    logic       reply_valid;
    logic       reply_request;
    logic [1:0] reply_status;
    logic       finished;
  } res_t;

  // configuration
  logic [7:0] first_addr_r;
  logic [4:0] first_cnt_r;
  logic       second_en_r;
  logic [7:0] second_addr_r;
  logic [4:0] second_cnt_r;

  // sequencer state
  logic [2:0]       phase_r, phase_nxt;
  logic             act_r, act_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic     out_valid_r;
  res_t     res_r, res_nxt;
  logic     in_fire;
  wbuf_wr_t wr;
  logic [7:0] buf_byte;

  logic [4:0]       req_cnt_raw;
  logic [CNT_W-1:0] req_n;
  logic [7:0]       req_addr;
  logic [7:0]       status;
  logic [CNT_W-1:0] cnt_inc;
  logic             do_fail;
  logic [1:0]       fail_code;
  logic             do_done;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_addr_r  <= '0;
      first_cnt_r   <= '0;
      second_en_r   <= 1'b0;
      second_addr_r <= '0;
      second_cnt_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_ADDR:  first_addr_r  <= cfg_data;
        CFG_FIRST_CNT:   first_cnt_r   <= cfg_data[4:0];
        CFG_SECOND_EN:   second_en_r   <= cfg_data[0];
        CFG_SECOND_ADDR: second_addr_r <= cfg_data;
        CFG_SECOND_CNT:  second_cnt_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign wr.en   = in_fire && (in_action == ACT_LOAD);
  assign wr.req  = in_load_request;
  assign wr.idx  = in_load_index;
  assign wr.data = in_load_byte;

  twims_wbuf #(
    .MAX_BYTES(MAX_BYTES)
  ) u_wbuf (
    .clk    (clk),
    .wr     (wr),
    .rd_req (act_nxt),
    .rd_idx (IDX_W'(cnt_nxt)),
    .rd_data(buf_byte)
  );

  assign req_cnt_raw = act_r ? second_cnt_r : first_cnt_r;
  assign req_n       = (32'(req_cnt_raw) > MAX_BYTES) ? CNT_W'(MAX_BYTES) : CNT_W'(req_cnt_raw);
  assign req_addr    = act_r ? second_addr_r : first_addr_r;
  assign status      = in_bus_status & ST_MASK;
  assign cnt_inc     = (32'(cnt_r) < MAX_BYTES) ? cnt_r + CNT_W'(1) : cnt_r;

  always_comb begin
    phase_nxt = phase_r;
    act_nxt   = act_r;
    cnt_nxt   = cnt_r;
    res_nxt   = '0;
    do_fail   = 1'b0;
    fail_code = RPL_OK;
    do_done   = 1'b0;

    if (in_fire) begin
      case (in_action)
        ACT_START: begin
          if (phase_r == PH_IDLE) begin
            act_nxt            = 1'b0;
            cnt_nxt            = '0;
            res_nxt.ctrl_valid = 1'b1;
            res_nxt.start_cmd  = 1'b1;
            res_nxt.bus_enable = 1'b1;
            phase_nxt          = PH_START;
          end
        end
        ACT_EVENT: begin
          unique case (phase_r)
            PH_START: begin
              if (status == ST_START || status == ST_RESTART) begin
                res_nxt.ctrl_valid = 1'b1;
                res_nxt.bus_enable = 1'b1;
                res_nxt.data_kind  = KIND_TX;
                res_nxt.data_value = req_addr;
                cnt_nxt            = '0;
                phase_nxt          = req_addr[0] ? PH_MR_ADDR : PH_MT_ADDR;
              end else begin
                do_fail   = 1'b1;
                fail_code = RPL_BAD_STAT;
              end
            end
            PH_MT_ADDR: begin
              if (status == ST_MT_SLA_ACK) begin
                if (req_n == '0) begin
                  do_fail = 1'b1;
                end else begin
                  res_nxt.ctrl_valid = 1'b1;
                  res_nxt.bus_enable = 1'b1;
                  res_nxt.data_kind  = KIND_TX;
                  res_nxt.data_value = buf_byte;
                  cnt_nxt            = CNT_W'(1);
                  phase_nxt          = PH_MT_DATA;
                end
              end else begin
                do_fail   = 1'b1;
                fail_code = (status == ST_MT_SLA_NACK) ? RPL_ADDR_NACK : RPL_BAD_STAT;
              end
            end
            PH_MT_DATA: begin
              if (status == ST_MT_DATA_ACK) begin
                if (cnt_r >= req_n) begin
                  do_done = 1'b1;
                end else begin
                  res_nxt.ctrl_valid = 1'b1;
                  res_nxt.bus_enable = 1'b1;
                  res_nxt.data_kind  = KIND_TX;
                  res_nxt.data_value = buf_byte;
                  cnt_nxt            = cnt_inc;
                end
              end else begin
                do_fail   = 1'b1;
                fail_code = (status == ST_MT_DATA_NACK) ? RPL_DATA_NACK : RPL_BAD_STAT;
              end
            end
            PH_MR_ADDR: begin
              if (status == ST_MR_SLA_ACK) begin
                if (req_n == '0) begin
                  do_fail = 1'b1;
                end else begin
                  res_nxt.ctrl_valid = 1'b1;
                  res_nxt.bus_enable = 1'b1;
                  res_nxt.ack_next   = req_n > CNT_W'(1);
                  cnt_nxt            = '0;
                  phase_nxt          = PH_MR_DATA;
                end
              end else begin
                do_fail   = 1'b1;
                fail_code = (status == ST_MR_SLA_NACK) ? RPL_ADDR_NACK : RPL_BAD_STAT;
              end
            end
            PH_MR_DATA: begin
              if (status == ST_MR_DATA_ACK || status == ST_MR_DATA_NACK) begin
                res_nxt.data_kind  = KIND_RX;
                res_nxt.data_value = in_rx_byte;
                res_nxt.data_index = 4'(cnt_r);
                cnt_nxt            = cnt_inc;
                if (status == ST_MR_DATA_ACK) begin
                  res_nxt.ctrl_valid = 1'b1;
                  res_nxt.bus_enable = 1'b1;
                  // NACK the byte that completes the count
                  res_nxt.ack_next   = ({1'b0, cnt_inc} + (CNT_W + 1)'(1)) < {1'b0, req_n};
                end else begin
                  do_done = 1'b1;
                end
              end else begin
                do_fail   = 1'b1;
                fail_code = RPL_BAD_STAT;
              end
            end
            default: begin
              // idle: drop the bus engine
              res_nxt.ctrl_valid = 1'b1;
              phase_nxt          = PH_IDLE;
            end
          endcase
        end
        default: ;
      endcase
    end

    if (do_fail) begin
      res_nxt.ctrl_valid    = 1'b1;
      res_nxt.bus_enable    = 1'b1;
      res_nxt.send_stop     = 1'b1;
      res_nxt.reply_valid   = 1'b1;
      res_nxt.reply_request = act_r;
      res_nxt.reply_status  = fail_code;
      res_nxt.finished      = 1'b1;
      phase_nxt             = PH_IDLE;
    end

    if (do_done) begin
      res_nxt.ctrl_valid    = 1'b1;
      res_nxt.bus_enable    = 1'b1;
      res_nxt.ack_next      = 1'b0;
      res_nxt.reply_valid   = 1'b1;
      res_nxt.reply_request = act_r;
      res_nxt.reply_status  = RPL_OK;
      if (!act_r && second_en_r) begin
        // chain to the second request with a repeated start
        act_nxt           = 1'b1;
        cnt_nxt           = '0;
        res_nxt.start_cmd = 1'b1;
        phase_nxt         = PH_START;
      end else begin
        res_nxt.send_stop = 1'b1;
        res_nxt.finished  = 1'b1;
        phase_nxt         = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      act_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      act_r   <= act_nxt;
      cnt_r   <= cnt_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ctrl_valid    = res_r.ctrl_valid;
  assign out_start_cmd     = res_r.start_cmd;
  assign out_send_stop     = res_r.send_stop;
  assign out_ack_next      = res_r.ack_next;
  assign out_bus_enable    = res_r.bus_enable;
  assign out_data_kind     = res_r.data_kind;
  assign out_data_value    = res_r.data_value;
  assign out_data_index    = res_r.data_index;
  assign out_reply_valid   = res_r.reply_valid;
  assign out_reply_request = res_r.reply_request;
  assign out_reply_status  = res_r.reply_status;
  assign out_finished      = res_r.finished;

endmodule
`default_nettype wire

### design/twims_wbuf.sv
// Write byte buffer with a registered prefetch read and same-cycle write forwarding.
`default_nettype none
module twims_wbuf #(
  parameter int MAX_BYTES = 16
) (
  input  wire                     clk,
  input  twims_pkg::wbuf_wr_t     wr,
  input  wire                     rd_req,
  input  wire [((MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1)-1:0] rd_idx,
  output logic [7:0]              rd_data
);
  import twims_pkg::*;

  localparam int DEPTH = 2 * MAX_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic          wr_ok;
  logic          rd_ok;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign wr_ok   = wr.en && (32'(wr.idx) < MAX_BYTES);
  assign rd_ok   = 32'(rd_idx) < MAX_BYTES;
  assign wr_addr = wr.req ? AW'(MAX_BYTES) + AW'(wr.idx) : AW'(wr.idx);
  assign rd_addr = rd_req ? AW'(MAX_BYTES) + AW'(rd_idx) : AW'(rd_idx);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // keep the byte at the current position ready for the next request
  always_ff @(posedge clk) begin
    if (rd_ok) begin
      rd_data_r <= (wr_ok && (wr_addr == rd_addr)) ? wr.data : mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire
